>>> hw/rtl/rpn_pkg.sv
// Shared types and constants for the typed RPN stack calculator.
package rpn_pkg;

    typedef enum logic [4:0] {
        KIND_PUSH  = 5'd0,
        KIND_TRUE  = 5'd1,
        KIND_FALSE = 5'd2,
        KIND_NOT   = 5'd3,
        KIND_PRINT = 5'd4,
        KIND_CLEAR = 5'd5,
        KIND_DROP  = 5'd6,
        KIND_DUP   = 5'd7,
        KIND_SWAP  = 5'd8,
        KIND_ADD   = 5'd9,
        KIND_SUB   = 5'd10,
        KIND_MUL   = 5'd11,
        KIND_DIV   = 5'd12,
        KIND_MOD   = 5'd13,
        KIND_LT    = 5'd14,
        KIND_GT    = 5'd15,
        KIND_LE    = 5'd16,
        KIND_GE    = 5'd17,
        KIND_EQ    = 5'd18
    } kind_t;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_EMPTY     = 3'd1;
    localparam logic [2:0] STS_NOT_BOOL  = 3'd2;
    localparam logic [2:0] STS_NOT_INT   = 3'd3;
    localparam logic [2:0] STS_DIV_ZERO  = 3'd4;
    localparam logic [2:0] STS_FULL      = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_TOP,
        S_RD_SEC,
        S_CAP_SEC,
        S_EXEC,
        S_DIV_WAIT,
        S_WRITE,
        S_SWAP2,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_DEC2,
        CNT_CLR
    } cnt_op_t;

    typedef enum logic [1:0] {
        WA_CNT,
        WA_TOP,
        WA_SEC
    } waddr_sel_t;

    typedef enum logic [2:0] {
        WD_VALUE,
        WD_BOOL,
        WD_TOP,
        WD_SEC,
        WD_ALU,
        WD_DIV
    } wdata_sel_t;

    typedef struct packed {
        logic [4:0]         kind;
        logic signed [31:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               has_print;
        logic signed [31:0] print_value;
        logic               print_is_bool;
        logic [6:0]         depth;
    } rsp_item_t;

    typedef struct packed {
        logic       load;
        logic       rd_sec;
        logic       cap_top;
        logic       cap_sec;
        logic       alu_en;
        logic       div_start;
        logic       wr_en;
        waddr_sel_t wr_addr;
        wdata_sel_t wr_data;
        cnt_op_t    cnt_op;
        logic       res_en;
        logic       print_en;
        logic [2:0] status;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  cnt_zero;
        logic  cnt_one;
        logic  cnt_full;
        logic  top_bool;
        logic  sec_bool;
        logic  top_zero;
        logic  div_done;
    } dp_stat_t;

endpackage

>>> hw/rtl/typed_rpn_stack_calculator_core.sv
// Top level of the typed RPN stack calculator: controller plus datapath.
// Sequence: the item is loaded at the accepting edge, then passes S_RD_TOP, S_RD_SEC,
// S_CAP_SEC, S_EXEC, S_WRITE and S_DONE; swap adds S_SWAP2, and divide or mod with valid
// operands waits in S_DIV_WAIT for the bit-serial divider. Throughput: one item at a time;
// busy drops the cycle after done. The receiver cannot stall.
// Reset: rst_n clears the stack count and the controller; stack memory is not cleared.
module typed_rpn_stack_calculator_core #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  rpn_pkg::cmd_item_t cmd,
    output logic               busy,
    output logic               done,
    output rpn_pkg::rsp_item_t rsp
);

    rpn_pkg::ctrl_cmd_t ctl;
    rpn_pkg::dp_stat_t  stat;
    logic               start_ok;

    assign start_ok = start && !busy;

    rpn_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start_ok),
        .stat (stat),
        .ctl  (ctl),
        .busy (busy),
        .done (done)
    );

    rpn_dp #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dp (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd),
        .ctl  (ctl),
        .stat (stat),
        .rsp  (rsp)
    );

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start_ok |=> busy)
        else $error("accepted item did not raise busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status <= rpn_pkg::STS_FULL))
        else $error("status code out of range");
    a_print_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.has_print) |-> (rsp.print_value == 32'sd0 && !rsp.print_is_bool))
        else $error("print fields set without a print");
`endif

endmodule

>>> hw/rtl/rpn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rpn_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            we,
    input  logic [$clog2(DEPTH)-1:0]        waddr,
    input  logic [WIDTH-1:0]                wdata,
    input  logic [$clog2(DEPTH)-1:0]        raddr,
    output logic [WIDTH-1:0]                rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/rpn_div.sv
// Signed 32-bit restoring divider, one quotient bit per cycle.
module rpn_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);

    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [4:0]  step_reg, step_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic        negq_reg, negq_next;
    logic        negr_reg, negr_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        shifted   = {rem_reg, quo_reg[31]};
        diff      = shifted - {1'b0, den_reg};
        if (start)
        begin
            run_next  = 1'b1;
            step_next = 5'd31;
            quo_next  = dividend[31] ? 32'd0 - dividend : dividend;
            den_next  = divisor[31] ? 32'd0 - divisor : divisor;
            rem_next  = 32'd0;
            negq_next = dividend[31] ^ divisor[31];
            negr_next = dividend[31];
        end
        else if (run_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            step_next = step_reg - 5'd1;
            if (step_reg == 5'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 5'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
    end

    assign done      = done_reg;
    assign quotient  = negq_reg ? 32'd0 - quo_reg : quo_reg;
    assign remainder = negr_reg ? 32'd0 - rem_reg : rem_reg;

endmodule

>>> hw/rtl/rpn_dp.sv
// Datapath: stack memory, stack count, operand registers, ALU, divider and result.
module rpn_dp #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rpn_pkg::cmd_item_t cmd,
    input  rpn_pkg::ctrl_cmd_t ctl,
    output rpn_pkg::dp_stat_t  stat,
    output rpn_pkg::rsp_item_t rsp
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [CW-1:0]      count_reg, count_next;
    rpn_pkg::kind_t     kind_reg;
    logic [31:0]        value_reg;
    logic [32:0]        top_reg;
    logic [32:0]        sec_reg;
    logic [31:0]        alu_reg, alu_next;
    logic               bool_reg, bool_next;
    logic [2:0]         status_reg;
    logic               has_print_reg;
    logic [31:0]        pv_reg;
    logic               pb_reg;
    logic [AW-1:0]      top_addr, sec_addr, cnt_addr, raddr, waddr;
    logic [32:0]        wdata, rdata;
    logic               div_done;
    logic [31:0]        quo, rem;

    assign top_addr = AW'(count_reg - CW'(1));
    assign sec_addr = AW'(count_reg - CW'(2));
    assign cnt_addr = AW'(count_reg);
    assign raddr    = ctl.rd_sec ? sec_addr : top_addr;

    always_comb
    begin
        unique case (ctl.wr_addr)
            rpn_pkg::WA_CNT: waddr = cnt_addr;
            rpn_pkg::WA_TOP: waddr = top_addr;
            rpn_pkg::WA_SEC: waddr = sec_addr;
            default:         waddr = cnt_addr;
        endcase
        unique case (ctl.wr_data)
            rpn_pkg::WD_VALUE: wdata = {1'b0, value_reg};
            rpn_pkg::WD_BOOL:  wdata = {1'b1, 31'd0, bool_reg};
            rpn_pkg::WD_TOP:   wdata = top_reg;
            rpn_pkg::WD_SEC:   wdata = sec_reg;
            rpn_pkg::WD_ALU:   wdata = {1'b0, alu_reg};
            rpn_pkg::WD_DIV:   wdata = {1'b0, (kind_reg == rpn_pkg::KIND_MOD) ? rem : quo};
            default:           wdata = {1'b0, alu_reg};
        endcase
    end

    rpn_ram #(
        .WIDTH(33),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk  (clk),
        .we   (ctl.wr_en),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    rpn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (sec_reg[31:0]),
        .divisor  (top_reg[31:0]),
        .done     (div_done),
        .quotient (quo),
        .remainder(rem)
    );

    always_comb
    begin
        alu_next  = 32'd0;
        bool_next = 1'b0;
        unique case (kind_reg)
            rpn_pkg::KIND_TRUE: bool_next = 1'b1;
            rpn_pkg::KIND_NOT:  bool_next = ~top_reg[0];
            rpn_pkg::KIND_ADD:  alu_next  = sec_reg[31:0] + top_reg[31:0];
            rpn_pkg::KIND_SUB:  alu_next  = sec_reg[31:0] - top_reg[31:0];
            rpn_pkg::KIND_MUL:  alu_next  = sec_reg[31:0] * top_reg[31:0];
            rpn_pkg::KIND_LT:   bool_next = $signed(sec_reg[31:0]) < $signed(top_reg[31:0]);
            rpn_pkg::KIND_GT:   bool_next = $signed(sec_reg[31:0]) > $signed(top_reg[31:0]);
            rpn_pkg::KIND_LE:   bool_next = $signed(sec_reg[31:0]) <= $signed(top_reg[31:0]);
            rpn_pkg::KIND_GE:   bool_next = $signed(sec_reg[31:0]) >= $signed(top_reg[31:0]);
            rpn_pkg::KIND_EQ:   bool_next = (top_reg == sec_reg);
            default:            bool_next = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (ctl.cnt_op)
            rpn_pkg::CNT_HOLD: count_next = count_reg;
            rpn_pkg::CNT_INC:  count_next = count_reg + CW'(1);
            rpn_pkg::CNT_DEC:  count_next = count_reg - CW'(1);
            rpn_pkg::CNT_DEC2: count_next = count_reg - CW'(2);
            rpn_pkg::CNT_CLR:  count_next = '0;
            default:           count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            kind_reg  <= rpn_pkg::kind_t'(cmd.kind);
            value_reg <= cmd.value;
        end
        if (ctl.cap_top)
        begin
            top_reg <= rdata;
        end
        if (ctl.cap_sec)
        begin
            sec_reg <= rdata;
        end
        if (ctl.alu_en)
        begin
            alu_reg  <= alu_next;
            bool_reg <= bool_next;
        end
        if (ctl.res_en)
        begin
            status_reg    <= ctl.status;
            has_print_reg <= ctl.print_en;
            pv_reg        <= ctl.print_en ? top_reg[31:0] : 32'd0;
            pb_reg        <= ctl.print_en ? top_reg[32] : 1'b0;
        end
    end

    assign stat.kind     = kind_reg;
    assign stat.cnt_zero = (count_reg == '0);
    assign stat.cnt_one  = (count_reg == CW'(1));
    assign stat.cnt_full = (count_reg >= CW'(STACK_DEPTH));
    assign stat.top_bool = top_reg[32];
    assign stat.sec_bool = sec_reg[32];
    assign stat.top_zero = (top_reg[31:0] == 32'd0);
    assign stat.div_done = div_done;

    assign rsp.status        = status_reg;
    assign rsp.has_print     = has_print_reg;
    assign rsp.print_value   = pv_reg;
    assign rsp.print_is_bool = pb_reg;
    assign rsp.depth         = 7'(count_reg);

endmodule

>>> hw/rtl/rpn_ctrl.sv
// Controller state machine that sequences each command item through the datapath.
module rpn_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  rpn_pkg::dp_stat_t  stat,
    output rpn_pkg::ctrl_cmd_t ctl,
    output logic               busy,
    output logic               done
);

    rpn_pkg::state_t state_reg, state_next;
    logic            is_binop;
    logic            is_divop;
    logic            is_cmp;
    logic            div_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpn_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        is_divop = (stat.kind == rpn_pkg::KIND_DIV) || (stat.kind == rpn_pkg::KIND_MOD);
        is_cmp   = (stat.kind == rpn_pkg::KIND_LT) || (stat.kind == rpn_pkg::KIND_GT) ||
                   (stat.kind == rpn_pkg::KIND_LE) || (stat.kind == rpn_pkg::KIND_GE);
        is_binop = is_divop || is_cmp || (stat.kind == rpn_pkg::KIND_ADD) ||
                   (stat.kind == rpn_pkg::KIND_SUB) || (stat.kind == rpn_pkg::KIND_MUL);
        div_go   = is_divop && !stat.cnt_zero && !stat.cnt_one && !stat.top_bool &&
                   !stat.sec_bool && !stat.top_zero;

        ctl            = '0;
        ctl.wr_addr    = rpn_pkg::WA_CNT;
        ctl.wr_data    = rpn_pkg::WD_VALUE;
        ctl.cnt_op     = rpn_pkg::CNT_HOLD;
        ctl.status     = rpn_pkg::STS_OK;
        state_next     = state_reg;

        unique case (state_reg)
            rpn_pkg::S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = rpn_pkg::S_RD_TOP;
                end
            end
            rpn_pkg::S_RD_TOP:
            begin
                state_next = rpn_pkg::S_RD_SEC;
            end
            rpn_pkg::S_RD_SEC:
            begin
                ctl.rd_sec  = 1'b1;
                ctl.cap_top = 1'b1;
                state_next  = rpn_pkg::S_CAP_SEC;
            end
            rpn_pkg::S_CAP_SEC:
            begin
                ctl.cap_sec = 1'b1;
                state_next  = rpn_pkg::S_EXEC;
            end
            rpn_pkg::S_EXEC:
            begin
                ctl.alu_en = 1'b1;
                if (div_go)
                begin
                    ctl.div_start = 1'b1;
                    state_next    = rpn_pkg::S_DIV_WAIT;
                end
                else
                begin
                    state_next = rpn_pkg::S_WRITE;
                end
            end
            rpn_pkg::S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = rpn_pkg::S_WRITE;
                end
            end
            rpn_pkg::S_WRITE:
            begin
                ctl.res_en = 1'b1;
                state_next = rpn_pkg::S_DONE;
                if (is_binop)
                begin
                    if (stat.cnt_zero)
                    begin
                        ctl.status = rpn_pkg::STS_EMPTY;
                    end
                    else if (stat.top_bool)
                    begin
                        ctl.status = rpn_pkg::STS_NOT_INT;
                        ctl.cnt_op = stat.cnt_one ? rpn_pkg::CNT_DEC : rpn_pkg::CNT_DEC2;
                    end
                    else if (stat.cnt_one)
                    begin
                        ctl.status = rpn_pkg::STS_EMPTY;
                        ctl.cnt_op = rpn_pkg::CNT_DEC;
                    end
                    else if (stat.sec_bool)
                    begin
                        ctl.status = rpn_pkg::STS_NOT_INT;
                        ctl.cnt_op = rpn_pkg::CNT_DEC2;
                    end
                    else if (is_divop && stat.top_zero)
                    begin
                        ctl.status = rpn_pkg::STS_DIV_ZERO;
                        ctl.cnt_op = rpn_pkg::CNT_DEC2;
                    end
                    else
                    begin
                        ctl.wr_en   = 1'b1;
                        ctl.wr_addr = rpn_pkg::WA_SEC;
                        ctl.wr_data = is_cmp ? rpn_pkg::WD_BOOL :
                                      (is_divop ? rpn_pkg::WD_DIV : rpn_pkg::WD_ALU);
                        ctl.cnt_op  = rpn_pkg::CNT_DEC;
                    end
                end
                else
                begin
                    unique case (stat.kind)
                        rpn_pkg::KIND_PUSH, rpn_pkg::KIND_TRUE, rpn_pkg::KIND_FALSE:
                        begin
                            if (stat.cnt_full)
                            begin
                                ctl.status = rpn_pkg::STS_FULL;
                            end
                            else
                            begin
                                ctl.wr_en   = 1'b1;
                                ctl.wr_addr = rpn_pkg::WA_CNT;
                                ctl.wr_data = (stat.kind == rpn_pkg::KIND_PUSH) ?
                                              rpn_pkg::WD_VALUE : rpn_pkg::WD_BOOL;
                                ctl.cnt_op  = rpn_pkg::CNT_INC;
                            end
                        end
                        rpn_pkg::KIND_NOT:
                        begin
                            if (stat.cnt_zero)
                            begin
                                ctl.status = rpn_pkg::STS_EMPTY;
                            end
                            else if (!stat.top_bool)
                            begin
                                ctl.status = rpn_pkg::STS_NOT_BOOL;
                            end
                            else
                            begin
                                ctl.wr_en   = 1'b1;
                                ctl.wr_addr = rpn_pkg::WA_TOP;
                                ctl.wr_data = rpn_pkg::WD_BOOL;
                            end
                        end
                        rpn_pkg::KIND_PRINT:
                        begin
                            if (stat.cnt_zero)
                            begin
                                ctl.status = rpn_pkg::STS_EMPTY;
                            end
                            else
                            begin
                                ctl.print_en = 1'b1;
                            end
                        end
                        rpn_pkg::KIND_CLEAR:
                        begin
                            ctl.cnt_op = rpn_pkg::CNT_CLR;
                        end
                        rpn_pkg::KIND_DROP:
                        begin
                            if (stat.cnt_zero)
                            begin
                                ctl.status = rpn_pkg::STS_EMPTY;
                            end
                            else
                            begin
                                ctl.cnt_op = rpn_pkg::CNT_DEC;
                            end
                        end
                        rpn_pkg::KIND_DUP:
                        begin
                            if (stat.cnt_zero)
                            begin
                                ctl.status = rpn_pkg::STS_EMPTY;
                            end
                            else if (stat.cnt_full)
                            begin
                                ctl.status = rpn_pkg::STS_FULL;
                            end
                            else
                            begin
                                ctl.wr_en   = 1'b1;
                                ctl.wr_addr = rpn_pkg::WA_CNT;
                                ctl.wr_data = rpn_pkg::WD_TOP;
                                ctl.cnt_op  = rpn_pkg::CNT_INC;
                            end
                        end
                        rpn_pkg::KIND_SWAP:
                        begin
                            if (stat.cnt_zero || stat.cnt_one)
                            begin
                                ctl.status = rpn_pkg::STS_EMPTY;
                            end
                            else
                            begin
                                ctl.wr_en   = 1'b1;
                                ctl.wr_addr = rpn_pkg::WA_TOP;
                                ctl.wr_data = rpn_pkg::WD_SEC;
                                state_next  = rpn_pkg::S_SWAP2;
                            end
                        end
                        rpn_pkg::KIND_EQ:
                        begin
                            if (stat.cnt_zero)
                            begin
                                ctl.status = rpn_pkg::STS_EMPTY;
                            end
                            else if (stat.cnt_one)
                            begin
                                ctl.status = rpn_pkg::STS_EMPTY;
                                ctl.cnt_op = rpn_pkg::CNT_DEC;
                            end
                            else
                            begin
                                ctl.wr_en   = 1'b1;
                                ctl.wr_addr = rpn_pkg::WA_SEC;
                                ctl.wr_data = rpn_pkg::WD_BOOL;
                                ctl.cnt_op  = rpn_pkg::CNT_DEC;
                            end
                        end
                        default:
                        begin
                            ctl.status = rpn_pkg::STS_OK;
                        end
                    endcase
                end
            end
            rpn_pkg::S_SWAP2:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_addr = rpn_pkg::WA_SEC;
                ctl.wr_data = rpn_pkg::WD_TOP;
                state_next  = rpn_pkg::S_DONE;
            end
            rpn_pkg::S_DONE:
            begin
                state_next = rpn_pkg::S_IDLE;
            end
            default:
            begin
                state_next = rpn_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != rpn_pkg::S_IDLE);
    assign done = (state_reg == rpn_pkg::S_DONE);

endmodule
